>>> src/dcled_pkg.sv
// Shared types and constants for the daisy-chain LED driver register writer.
`default_nettype none

package dcled_pkg;

    // Serial word geometry
    localparam int WORD_BITS   = 16;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 8;
    localparam int ADDR_PAD    = WORD_BITS - DATA_BITS - ADDR_BITS;
    localparam int MAX_CHAIN   = 4;
    localparam int BIT_CNT_W   = $clog2(WORD_BITS);
    localparam int WORD_CNT_W  = $clog2(MAX_CHAIN);

    localparam logic [WORD_BITS-1:0] NOOP_WORD = 16'h0000;

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BCAST = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } dcled_state_t;

    // Controls from the sequencer to the shift path
    typedef struct packed {
        logic load_first;   // load first word of the frame from the inputs
        logic load_next;    // load the next word at a word boundary
        logic use_word;     // loaded word is the register word, else no-op
    } dcled_ctl_t;

endpackage

`default_nettype wire

>>> src/dcled_shift.sv
// Word holding register and MSB-first output shift register.
`default_nettype none

module dcled_shift
    import dcled_pkg::*;
(
    input  wire logic                 clk,
    input  wire dcled_ctl_t           ctl,
    input  wire logic [ADDR_BITS-1:0] reg_address,
    input  wire logic [DATA_BITS-1:0] reg_data,
    output logic                      serial_bit
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [WORD_BITS-1:0] shift_reg;
    logic [WORD_BITS-1:0] shift_next;

    // Capture the register word at the start of a frame
    always_comb
    begin
        word_next = word_reg;
        if (ctl.load_first)
        begin
            word_next = {{ADDR_PAD{1'b0}}, reg_address, reg_data};
        end
    end

    // Load a word or advance one bit toward the MSB
    always_comb
    begin
        if (ctl.load_first)
        begin
            shift_next = ctl.use_word ? word_next : NOOP_WORD;
        end
        else if (ctl.load_next)
        begin
            shift_next = ctl.use_word ? word_reg : NOOP_WORD;
        end
        else
        begin
            shift_next = {shift_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        shift_reg <= shift_next;
    end

    assign serial_bit = shift_reg[WORD_BITS-1];

endmodule

`default_nettype wire

>>> src/dcled_ctrl.sv
// Frame sequencer: bit and word counters and the send state machine.
`default_nettype none

module dcled_ctrl
    import dcled_pkg::*;
#(
    parameter int CHAIN_LENGTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] op,
    input  wire logic [1:0] target_module,
    output dcled_ctl_t      ctl,
    output logic            busy,
    output logic            bit_strobe,
    output logic            frame_end
);

    localparam int CHAIN_EFF = (CHAIN_LENGTH < 1) ? 1 :
                               ((CHAIN_LENGTH > MAX_CHAIN) ? MAX_CHAIN : CHAIN_LENGTH);
    localparam logic [WORD_CNT_W-1:0] LAST_POS = WORD_CNT_W'(CHAIN_EFF - 1);
    localparam logic [BIT_CNT_W-1:0]  LAST_BIT = BIT_CNT_W'(WORD_BITS - 1);

    dcled_state_t            state_reg, state_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [WORD_CNT_W-1:0]   word_cnt_reg, word_cnt_next;
    logic                    bcast_reg, bcast_next;
    logic [WORD_CNT_W-1:0]   target_sat;
    logic                    accept;

    // Saturate the target to the last chain position
    assign target_sat = (target_module > LAST_POS) ? LAST_POS : target_module;
    assign accept     = start && (state_reg == ST_IDLE) && (op != OP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            word_cnt_reg <= '0;
            bcast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            word_cnt_reg <= word_cnt_next;
            bcast_reg    <= bcast_next;
        end
    end

    // Next state, counters and shift controls
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        word_cnt_next  = word_cnt_reg;
        bcast_next     = bcast_reg;
        ctl            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_SEND;
                    bit_cnt_next   = '0;
                    bcast_next     = (op == OP_BCAST);
                    word_cnt_next  = (op == OP_WRITE) ? target_sat : LAST_POS;
                    ctl.load_first = 1'b1;
                    ctl.use_word   = (op != OP_FLUSH);
                end
            end
            ST_SEND:
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    if (word_cnt_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_cnt_next = word_cnt_reg - 1'b1;
                        ctl.load_next = 1'b1;
                        ctl.use_word  = bcast_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg == ST_SEND);
    assign bit_strobe = (state_reg == ST_SEND);
    assign frame_end  = (state_reg == ST_SEND) && (bit_cnt_reg == LAST_BIT)
                        && (word_cnt_reg == '0);

endmodule

`default_nettype wire

>>> src/daisy_chain_led_driver_writer.sv
// Top level of the daisy-chain LED driver register writer.
//
//   channel   | handshake             | fields
//   ----------+-----------------------+--------------------------------------------
//   command   | start, busy           | op, target_module, reg_address, reg_data
//   result    | bit_strobe (no stall) | serial_bit, frame_end
//
// A frame leaves one bit per clock, starting the cycle after the command is
// taken: 16-bit words, up to CHAIN_LENGTH words (at most MAX_CHAIN), set by
// the bit and word counters of the sequencer. busy drops after the bit that
// carries frame_end, so a new command can be taken in the cycle after that bit.
// The unused op code is taken and yields no frame. Reset (rst_n, async, low)
// returns the sequencer to idle; the receiver cannot stall the bit stream.
`default_nettype none

module daisy_chain_led_driver_writer
    import dcled_pkg::*;
#(
    parameter int CHAIN_LENGTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           op,
    input  wire logic [1:0]           target_module,
    input  wire logic [ADDR_BITS-1:0] reg_address,
    input  wire logic [DATA_BITS-1:0] reg_data,
    output logic                      bit_strobe,
    output logic                      serial_bit,
    output logic                      frame_end
);

    dcled_ctl_t ctl;

    // Sequence words and bits of the frame
    dcled_ctrl #(
        .CHAIN_LENGTH (CHAIN_LENGTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .target_module (target_module),
        .ctl           (ctl),
        .busy          (busy),
        .bit_strobe    (bit_strobe),
        .frame_end     (frame_end)
    );

    // Hold and shift out the serial words
    dcled_shift u_shift (
        .clk         (clk),
        .ctl         (ctl),
        .reg_address (reg_address),
        .reg_data    (reg_data),
        .serial_bit  (serial_bit)
    );

endmodule

`default_nettype wire

>>> src/dcled_checker.sv
// Port-level checker for the daisy-chain LED driver writer, with its bind.
`default_nettype none

module dcled_props
    import dcled_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] op,
    input wire logic       bit_strobe,
    input wire logic       serial_bit,
    input wire logic       frame_end
);

    // A taken transaction with a real op starts its frame the next cycle
    a_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op != OP_NONE) |=> bit_strobe)
        else $error("frame did not start after accepted transaction");

    // The unused op code leaves the block idle
    a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == OP_NONE) |=> !bit_strobe)
        else $error("unused op produced a frame");

    // After the bit that carries frame_end, the stream stops
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> !bit_strobe)
        else $error("bits continued after frame end");

    // A flush frame opens with a zero bit
    a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == OP_FLUSH) |=> !serial_bit)
        else $error("flush frame sent a one");

    // Bits only leave while busy
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bit_strobe |-> busy)
        else $error("bit strobe while not busy");

endmodule

bind daisy_chain_led_driver_writer dcled_props u_dcled_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .bit_strobe (bit_strobe),
    .serial_bit (serial_bit),
    .frame_end  (frame_end)
);

`default_nettype wire

>>> verif/dcled_checker.sv
// Checker for the daisy-chain LED writer: watches commands and serial bits, predicts and compares.
`timescale 1ns / 100ps

module dcled_checker
    import dcled_pkg::*;
#(
    parameter int CHAIN_LENGTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [1:0]           op,
    input  wire logic [1:0]           target_module,
    input  wire logic [ADDR_BITS-1:0] reg_address,
    input  wire logic [DATA_BITS-1:0] reg_data,
    input  wire logic                 bit_strobe,
    input  wire logic                 serial_bit,
    input  wire logic                 frame_end,
    output int                        errors,
    output int                        pending,
    output int                        bits_checked
);

    typedef struct packed {
        logic serial_bit;
        logic frame_end;
    } line_bit_t;

    // Serial bits still owed by the block, oldest first
    line_bit_t frame_bits[$];

    initial
    begin
        errors       = 0;
        pending      = 0;
        bits_checked = 0;
    end

    // Number of modules on the chain, held to the supported range
    function automatic int chain_modules();
        int n;
        n = CHAIN_LENGTH;
        if (n < 1)
            n = 1;
        if (n > MAX_CHAIN)
            n = MAX_CHAIN;
        return n;
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Expand one command into the serial bits of its frame
    task automatic predict_frame(
        input logic [1:0]           cmd_op,
        input logic [1:0]           cmd_target,
        input logic [ADDR_BITS-1:0] cmd_addr,
        input logic [DATA_BITS-1:0] cmd_data
    );
        logic [WORD_BITS-1:0] reg_word;
        logic [WORD_BITS-1:0] words [MAX_CHAIN];
        int                   n_words;
        int                   target_pos;
        line_bit_t            lb;
        reg_word = {{ADDR_PAD{1'b0}}, cmd_addr, cmd_data};
        n_words  = 0;
        case (cmd_op)
            OP_WRITE:
            begin
                // Saturate a target past the end of the chain
                target_pos = int'(cmd_target);
                if (target_pos > chain_modules() - 1)
                    target_pos = chain_modules() - 1;
                words[0] = reg_word;
                n_words  = 1;
                for (int i = 0; i < target_pos; i++)
                begin
                    words[n_words] = NOOP_WORD;
                    n_words++;
                end
            end
            OP_BCAST:
            begin
                for (int i = 0; i < chain_modules(); i++)
                begin
                    words[n_words] = reg_word;
                    n_words++;
                end
            end
            OP_FLUSH:
            begin
                for (int i = 0; i < chain_modules(); i++)
                begin
                    words[n_words] = NOOP_WORD;
                    n_words++;
                end
            end
            default:
                n_words = 0;    // unused op: no frame
        endcase
        // Shift words out MSB first; mark the final bit of the frame
        for (int w = 0; w < n_words; w++)
        begin
            for (int b = WORD_BITS - 1; b >= 0; b--)
            begin
                lb.serial_bit = words[w][b];
                lb.frame_end  = (w == n_words - 1) && (b == 0);
                frame_bits.push_back(lb);
            end
        end
    endtask

    // Compare each strobed bit, then capture any accepted command
    always @(posedge clk)
    begin
        line_bit_t want;
        if (rst_n)
        begin
            if (bit_strobe !== 1'b0 && bit_strobe !== 1'b1)
                report("bit_strobe is unknown");
            else if (bit_strobe)
            begin
                if (frame_bits.size() == 0)
                    report("serial bit strobed with no frame bit outstanding");
                else
                begin
                    want = frame_bits.pop_front();
                    if (serial_bit !== want.serial_bit)
                        report($sformatf("serial_bit %b, expected %b",
                                         serial_bit, want.serial_bit));
                    if (frame_end !== want.frame_end)
                        report($sformatf("frame_end %b, expected %b",
                                         frame_end, want.frame_end));
                    bits_checked++;
                end
            end
            if (start && !busy)
                predict_frame(op, target_module, reg_address, reg_data);
            pending = frame_bits.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top for the daisy-chain LED writer: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import dcled_pkg::*;

    localparam int CHAIN       = 4;
    localparam int RANDOM_CMDS = 180;
    localparam int DRAIN_CYCLES = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           op = OP_WRITE;
    logic [1:0]           target_module = 2'd0;
    logic [ADDR_BITS-1:0] reg_address = '0;
    logic [DATA_BITS-1:0] reg_data = '0;
    logic                 bit_strobe;
    logic                 serial_bit;
    logic                 frame_end;

    int errors;
    int pending;
    int bits_checked;
    int op_count [4];
    int burst_left;

    daisy_chain_led_driver_writer #(
        .CHAIN_LENGTH(CHAIN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .target_module(target_module),
        .reg_address  (reg_address),
        .reg_data     (reg_data),
        .bit_strobe   (bit_strobe),
        .serial_bit   (serial_bit),
        .frame_end    (frame_end)
    );

    dcled_checker #(
        .CHAIN_LENGTH(CHAIN)
    ) frame_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .target_module(target_module),
        .reg_address  (reg_address),
        .reg_data     (reg_data),
        .bit_strobe   (bit_strobe),
        .serial_bit   (serial_bit),
        .frame_end    (frame_end),
        .errors       (errors),
        .pending      (pending),
        .bits_checked (bits_checked)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hold start with the command until the block takes the transaction
    task automatic issue_command(
        input logic [1:0]           cmd_op,
        input logic [1:0]           cmd_target,
        input logic [ADDR_BITS-1:0] cmd_addr,
        input logic [DATA_BITS-1:0] cmd_data
    );
        start         <= 1'b1;
        op            <= cmd_op;
        target_module <= cmd_target;
        reg_address   <= cmd_addr;
        reg_data      <= cmd_data;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        op_count[cmd_op]++;
    endtask

    // Drop start and wait out every outstanding frame bit
    task automatic drain_frames();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Sender idles in bursts: pick a new burst length and a gap when one runs out
    task automatic sender_pacing();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 4)
            gap = 0;
        else
            gap = $urandom_range(1, 80);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [1:0] rand_op;
        int         pick;
        foreach (op_count[i])
            op_count[i] = 0;
        burst_left = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: field extremes, every op, unused op, alternating bit patterns
        issue_command(OP_WRITE, 2'd0, 4'h0, 8'h00);
        issue_command(OP_WRITE, 2'd3, 4'hF, 8'hFF);
        issue_command(OP_WRITE, 2'd1, 4'hA, 8'h55);
        issue_command(OP_WRITE, 2'd2, 4'h5, 8'hAA);
        issue_command(OP_BCAST, 2'd0, 4'hF, 8'hFF);
        issue_command(OP_BCAST, 2'd3, 4'h0, 8'h00);
        issue_command(OP_BCAST, 2'd1, 4'hA, 8'h55);
        issue_command(OP_FLUSH, 2'd0, 4'h0, 8'h00);
        issue_command(OP_FLUSH, 2'd3, 4'hF, 8'hFF);
        issue_command(OP_NONE,  2'd2, 4'h5, 8'hAA);
        issue_command(OP_WRITE, 2'd3, 4'h1, 8'h80);
        issue_command(OP_NONE,  2'd3, 4'hF, 8'hFF);
        issue_command(OP_NONE,  2'd0, 4'h0, 8'h01);
        issue_command(OP_BCAST, 2'd2, 4'h8, 8'h01);
        issue_command(OP_WRITE, 2'd0, 4'hF, 8'hFF);
        issue_command(OP_FLUSH, 2'd1, 4'hA, 8'h55);

        // Let the chain go quiet before random traffic
        drain_frames();

        // Random: mostly real frames, some unused-op commands
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            sender_pacing();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                rand_op = OP_WRITE;
            else if (pick < 65)
                rand_op = OP_BCAST;
            else if (pick < 90)
                rand_op = OP_FLUSH;
            else
                rand_op = OP_NONE;
            issue_command(rand_op, 2'($urandom_range(0, 3)),
                          ADDR_BITS'($urandom), DATA_BITS'($urandom));
            if (n == RANDOM_CMDS / 2)
                drain_frames();
        end

        // Wind down and give any stray bits time to show up
        drain_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d writes, %0d broadcasts, %0d flushes, %0d unused-op.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_WRITE], op_count[OP_BCAST], op_count[OP_FLUSH],
                 op_count[OP_NONE]);
        $display("Checked %0d serial bits on a %0d-module chain, %0d mismatches.",
                 bits_checked, CHAIN, errors);
        if (errors == 0 && pending == 0)
            $display("daisy_chain_led_driver_writer regression: pass");
        else
            $display("daisy_chain_led_driver_writer regression: fail");
        $finish;
    end

    // Watchdog: stop a hung run
    initial
    begin
        #2000000;
        $display("Timed out with %0d frame bits outstanding.", pending);
        $display("daisy_chain_led_driver_writer regression: fail");
        $finish;
    end

endmodule
